// ===== hw/rtl/union_find_engine_core_defines.svh =====
// ----------------------------------------------------------------------------
// union_find_engine_core_defines.svh
// Assertion macros shared by the union-find engine RTL.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_ENGINE_CORE_DEFINES_SVH
`define UNION_FIND_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define UFE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define UFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ufe_pkg.sv =====
// ----------------------------------------------------------------------------
// ufe_pkg
// Types and constants of the union-find engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ufe_pkg;

	// Node field width and the number of indices it can carry
	localparam int NODE_W    = 10;
	localparam int NODE_SPAN = 1 << NODE_W;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [1:0]        action_t;

	// Request actions
	localparam action_t ACT_MAKE_SET = 2'd0;
	localparam action_t ACT_FIND     = 2'd1;
	localparam action_t ACT_UNION    = 2'd2;
	localparam action_t ACT_SAME     = 2'd3;

	// Access to the parent memory: one write and one read per cycle
	typedef struct packed {
		logic  wr_en;
		node_t wr_addr;
		node_t wr_data;
		node_t rd_addr;
	} mem_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ufe_ifs.sv =====
// ----------------------------------------------------------------------------
// ufe_ifs
// Request and response channels of the union-find engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface ufe_req_if;
	logic            valid;
	logic            ready;
	ufe_pkg::action_t action;
	ufe_pkg::node_t   first_node;
	ufe_pkg::node_t   second_node;

	modport source (output valid, action, first_node, second_node, input ready);
	modport sink   (input valid, action, first_node, second_node, output ready);
endinterface

interface ufe_rsp_if;
	logic           valid;
	logic           ready;
	ufe_pkg::node_t root;
	logic           same_set;

	modport source (output valid, root, same_set, input ready);
	modport sink   (input valid, root, same_set, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/union_find_engine_core.sv =====
// Union-find engine with path compression. After reset the engine runs a
// clearing pass over min(NODES, 1024) entries that points every node at
// itself; req.ready stays low until it ends. Requests are handled one at a
// time. The parent memory has one read port, so a root search reads one
// pointer per hop on the way up and rewrites the nodes of the path one by
// one on the way back. The result sits in an output register, so a waiting
// response does not stop the next request from being accepted; a second
// finished result waits for it. Node indices not below NODES are reduced
// modulo NODES.
`default_nettype none

// ----------------------------------------------------------------------------
// union_find_engine_core
// Top level: index reduction, request sequencer and parent memory.
// ----------------------------------------------------------------------------
module union_find_engine_core #(
	parameter int NODES = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ufe_req_if.sink   req,
	ufe_rsp_if.source rsp
);

	// Indices at or above the field span can never be addressed
	localparam int DEPTH = (NODES < ufe_pkg::NODE_SPAN) ? NODES : ufe_pkg::NODE_SPAN;
	localparam int AW    = $clog2(DEPTH);

	ufe_pkg::node_t    x_idx;
	ufe_pkg::node_t    y_idx;
	ufe_pkg::mem_req_t mem_req;
	ufe_pkg::node_t    rd_data;
	logic              init_done;

	// Reduce an index modulo NODES by restoring subtraction of NODES << k
	function automatic ufe_pkg::node_t reduce_idx(input ufe_pkg::node_t raw);
		ufe_pkg::node_t v;
		longint         step;
		v = raw;
		for (int k = ufe_pkg::NODE_W - 1; k >= 0; k--) begin
			step = longint'(NODES) << k;
			if (step < longint'(ufe_pkg::NODE_SPAN)) begin
				if (v >= ufe_pkg::node_t'(step)) begin
					v = v - ufe_pkg::node_t'(step);
				end
			end
		end
		return v;
	endfunction

	assign x_idx = reduce_idx(req.first_node);
	assign y_idx = reduce_idx(req.second_node);

	ufe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.x_idx     (x_idx),
		.y_idx     (y_idx),
		.init_done (init_done),
		.rd_data   (rd_data),
		.mem_req   (mem_req)
	);

	ufe_parent_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_parent_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (mem_req),
		.rd_data   (rd_data),
		.init_done (init_done)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ufe_parent_mem.sv =====
// ----------------------------------------------------------------------------
// ufe_parent_mem
// Parent pointer memory: one write and one registered read port, with a
// clearing pass after reset that points every entry at itself.
// ----------------------------------------------------------------------------
`default_nettype none

module ufe_parent_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ufe_pkg::mem_req_t req,
	output ufe_pkg::node_t         rd_data,
	output logic                   init_done
);

	logic [AW-1:0] mem [DEPTH];
	logic [AW-1:0] rd_q;
	logic [AW-1:0] clr_addr_q;
	logic          init_done_q;

	// Sweep the clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			init_done_q <= 1'b0;
		end else if (!init_done_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				init_done_q <= 1'b1;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Write: clearing pass first, then the engine's updates
	always_ff @(posedge clk) begin
		if (!init_done_q) begin
			mem[clr_addr_q] <= clr_addr_q;
		end else if (req.wr_en) begin
			mem[req.wr_addr[AW-1:0]] <= req.wr_data[AW-1:0];
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rd_q <= mem[req.rd_addr[AW-1:0]];
	end

	assign rd_data   = ufe_pkg::node_t'(rd_q);
	assign init_done = init_done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ufe_ctrl.sv =====
// ----------------------------------------------------------------------------
// ufe_ctrl
// Request sequencer: walks parent pointers to the root, rewrites the path,
// links roots and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "union_find_engine_core_defines.svh"

module ufe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	ufe_req_if.sink                req,
	ufe_rsp_if.source              rsp,
	input  wire ufe_pkg::node_t    x_idx,
	input  wire ufe_pkg::node_t    y_idx,
	input  wire logic              init_done,
	input  wire ufe_pkg::node_t    rd_data,
	output ufe_pkg::mem_req_t      mem_req
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_COMP = 3'd2;
	localparam logic [2:0] S_LINK = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]       state_q;
	ufe_pkg::action_t act_q;
	logic             phase_q;
	ufe_pkg::node_t   start_q;
	ufe_pkg::node_t   cur_q;
	ufe_pkg::node_t   root_q;
	ufe_pkg::node_t   y_q;
	ufe_pkg::node_t   rx_q;
	ufe_pkg::node_t   link_addr_q;
	ufe_pkg::node_t   link_data_q;
	ufe_pkg::node_t   res_root_q;
	logic             res_same_q;
	logic             out_valid_q;
	ufe_pkg::node_t   out_root_q;
	logic             out_same_q;

	logic           accept;
	logic           walk_hit;
	logic           comp_end;
	logic           find_done;
	ufe_pkg::node_t find_root;
	logic           out_load;

	assign req.ready = (state_q == S_IDLE) && init_done;
	assign accept    = req.valid && req.ready;

	// Detect the root on the first pass and the end of the rewrite pass
	assign walk_hit  = (state_q == S_WALK) && (rd_data == cur_q);
	assign comp_end  = (state_q == S_COMP) && (rd_data == root_q);
	assign find_done = (walk_hit && (start_q == cur_q)) || comp_end;
	assign find_root = walk_hit ? cur_q : root_q;
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	// Drive the memory port; a finished first search starts the second
	// node's walk in the same cycle. A same-cycle write to that node reads
	// the old pointer, which still leads to the same root.
	always_comb begin
		mem_req.wr_en   = (state_q == S_COMP) || (state_q == S_LINK);
		mem_req.wr_addr = (state_q == S_COMP) ? cur_q : link_addr_q;
		mem_req.wr_data = (state_q == S_COMP) ? root_q : link_data_q;
		mem_req.rd_addr = rd_data;
		if (state_q == S_IDLE) begin
			mem_req.rd_addr = x_idx;
		end else if (find_done) begin
			mem_req.rd_addr = y_q;
		end else if (walk_hit) begin
			mem_req.rd_addr = start_q;
		end
	end

	// Sequence one request at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= ufe_pkg::ACT_MAKE_SET;
			phase_q     <= 1'b0;
			start_q     <= '0;
			cur_q       <= '0;
			root_q      <= '0;
			y_q         <= '0;
			rx_q        <= '0;
			link_addr_q <= '0;
			link_data_q <= '0;
			res_root_q  <= '0;
			res_same_q  <= 1'b0;
		end else if (find_done) begin
			// Close a root search: start the second one or settle the result
			if (!phase_q) begin
				rx_q <= find_root;
				if (act_q == ufe_pkg::ACT_FIND) begin
					res_root_q <= find_root;
					res_same_q <= 1'b0;
					state_q    <= S_FIN;
				end else begin
					phase_q <= 1'b1;
					start_q <= y_q;
					cur_q   <= y_q;
					state_q <= S_WALK;
				end
			end else begin
				res_same_q <= (rx_q == find_root);
				if (act_q == ufe_pkg::ACT_UNION) begin
					res_root_q  <= find_root;
					link_addr_q <= rx_q;
					link_data_q <= find_root;
					state_q     <= S_LINK;
				end else begin
					res_root_q <= rx_q;
					state_q    <= S_FIN;
				end
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q   <= req.action;
						y_q     <= y_idx;
						start_q <= x_idx;
						cur_q   <= x_idx;
						phase_q <= 1'b0;
						if (req.action == ufe_pkg::ACT_MAKE_SET) begin
							link_addr_q <= x_idx;
							link_data_q <= x_idx;
							res_root_q  <= x_idx;
							res_same_q  <= 1'b0;
							state_q     <= S_LINK;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (walk_hit) begin
						root_q <= cur_q;
						cur_q  <= start_q;
						state_q <= S_COMP;
					end else begin
						cur_q <= rd_data;
					end
				end
				S_COMP: begin
					cur_q <= rd_data;
				end
				S_LINK: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the result until the response transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_root_q <= res_root_q;
			out_same_q <= res_same_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.root     = out_root_q;
	assign rsp.same_set = out_same_q;

	// A non-root node on the rewrite pass never points at itself
	`UFE_ASSERT_NOW(a_comp_no_self_loop, (state_q == S_COMP) && (rd_data != root_q), rd_data != cur_q, "path rewrite found a self loop below the root")
	// An accepted request always leaves idle
	`UFE_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != S_IDLE, "accepted request did not start")
	// Only union and same report a shared root
	`UFE_ASSERT_NOW(a_same_only_pairs, (state_q == S_FIN) && (act_q != ufe_pkg::ACT_UNION) && (act_q != ufe_pkg::ACT_SAME), !res_same_q, "same_set raised on a single-node action")
	// A loaded result shows up as a valid response and frees the sequencer
	`UFE_ASSERT_NEXT(a_fin_loads_output, out_load, rsp.valid && (state_q == S_IDLE), "result was not loaded into the output register")

endmodule

`default_nettype wire

// ===== bench/union_find_engine_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// union_find_engine_core_tb
// Self-checking bench for the union-find engine. A queue-fed driver sends
// make_set, find, union and same-set requests. Most of them work on small node
// windows and parent chains, so root searches and path compression run deep.
// A shadow parent table predicts every response, and a monitor checks the
// responses in order. Four phases vary request gaps and response stalls.
// ----------------------------------------------------------------------------
module union_find_engine_core_tb;

	localparam int NODES          = 1024;
	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 5;
	localparam int PHASE_ITEMS    = 325;
	localparam int QUIET_LIMIT    = 20000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASE_COUNT    = 4;

	typedef struct packed {
		ufe_pkg::action_t act;
		ufe_pkg::node_t   x;
		ufe_pkg::node_t   y;
	} request_t;

	typedef struct packed {
		ufe_pkg::node_t root;
		logic           same_set;
	} answer_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Request side drive registers, known from time zero
	logic             req_valid = 1'b0;
	ufe_pkg::action_t req_act   = ufe_pkg::ACT_MAKE_SET;
	ufe_pkg::node_t   req_x     = '0;
	ufe_pkg::node_t   req_y     = '0;
	logic             rsp_ready = 1'b0;

	ufe_req_if req_if ();
	ufe_rsp_if rsp_if ();

	assign req_if.valid       = req_valid;
	assign req_if.action      = req_act;
	assign req_if.first_node  = req_x;
	assign req_if.second_node = req_y;
	assign rsp_if.ready       = rsp_ready;

	union_find_engine_core #(
		.NODES(NODES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// Shadow state and bookkeeping
	ufe_pkg::node_t parent_q [NODES];
	request_t       backlog[$];
	answer_t        answers_due[$];
	int             send_idle_pct  = 0;
	int             recv_stall_pct = 0;
	int             fault_cnt      = 0;
	int             quiet_cycles   = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Walk to the root, then point every node on the walk at it
	function automatic ufe_pkg::node_t seek_root(input ufe_pkg::node_t start);
		ufe_pkg::node_t top;
		ufe_pkg::node_t walk;
		ufe_pkg::node_t nxt;
		int             hops;
		top  = start;
		hops = 0;
		while (parent_q[top] != top && hops < NODES) begin
			top = parent_q[top];
			hops++;
		end
		walk = start;
		hops = 0;
		while (walk != top && hops < NODES) begin
			nxt            = parent_q[walk];
			parent_q[walk] = top;
			walk           = nxt;
			hops++;
		end
		return top;
	endfunction

	// Apply one request to the shadow table and return its response
	function automatic answer_t resolve_request(input request_t rq);
		answer_t        ans;
		ufe_pkg::node_t rx;
		ufe_pkg::node_t ry;
		ans.root     = '0;
		ans.same_set = 1'b0;
		case (rq.act)
			ufe_pkg::ACT_MAKE_SET: begin
				parent_q[rq.x] = rq.x;
				ans.root       = rq.x;
			end
			ufe_pkg::ACT_FIND: begin
				ans.root = seek_root(rq.x);
			end
			ufe_pkg::ACT_UNION: begin
				rx           = seek_root(rq.x);
				ry           = seek_root(rq.y);
				ans.same_set = (rx == ry);
				parent_q[rx] = ry;
				ans.root     = ry;
			end
			default: begin
				rx           = seek_root(rq.x);
				ry           = seek_root(rq.y);
				ans.same_set = (rx == ry);
				ans.root     = rx;
			end
		endcase
		return ans;
	endfunction

	task automatic push_request(input ufe_pkg::action_t act, input ufe_pkg::node_t x,
		input ufe_pkg::node_t y);
		request_t rq;
		rq.act  = act;
		rq.x    = x;
		rq.y    = y;
		backlog = {backlog, rq};
	endtask

	// Driver: predict on each accepted transaction, then hold or advance
	always @(posedge clk) begin : drive_requests
		request_t cur;
		answer_t  due_ans;
		if (arst_n) begin
			if (req_valid && req_if.ready) begin
				cur.act     = req_act;
				cur.x       = req_x;
				cur.y       = req_y;
				due_ans     = resolve_request(cur);
				answers_due = {answers_due, due_ans};
			end
			if (!req_valid || req_if.ready) begin
				if (backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur = backlog.pop_front();
					req_valid <= 1'b1;
					req_act   <= cur.act;
					req_x     <= cur.x;
					req_y     <= cur.y;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each response transaction with the oldest prediction
	always @(posedge clk) begin : check_responses
		answer_t due;
		if (arst_n) begin
			if (rsp_if.valid && rsp_ready) begin
				if (answers_due.size() == 0) begin
					$error("unexpected response: root %0d, same_set %0d",
						rsp_if.root, rsp_if.same_set);
					fault_cnt++;
				end else begin
					due = answers_due.pop_front();
					if (rsp_if.root !== due.root) begin
						$error("root: expected %0d, actual %0d", due.root, rsp_if.root);
						fault_cnt++;
					end
					if (rsp_if.same_set !== due.same_set) begin
						$error("same_set: expected %0d, actual %0d",
							due.same_set, rsp_if.same_set);
						fault_cnt++;
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_if.ready) || (rsp_if.valid && rsp_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles = quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Stimulus and end of run
	initial begin : run_sequence
		int             added;
		int             mode;
		int             len;
		int             span;
		ufe_pkg::node_t base;
		for (int i = 0; i < NODES; i++) begin
			parent_q[i] = ufe_pkg::node_t'(i);
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: index extremes, every action, rejoin, make_set on a parent
		@(negedge clk);
		push_request(ufe_pkg::ACT_FIND, 10'd0, 10'd1023);
		push_request(ufe_pkg::ACT_FIND, 10'd1023, 10'd0);
		push_request(ufe_pkg::ACT_MAKE_SET, 10'd1023, 10'd1023);
		push_request(ufe_pkg::ACT_SAME, 10'd0, 10'd1023);
		push_request(ufe_pkg::ACT_UNION, 10'd0, 10'd1023);
		push_request(ufe_pkg::ACT_SAME, 10'd1023, 10'd0);
		push_request(ufe_pkg::ACT_UNION, 10'd0, 10'd1023);
		push_request(ufe_pkg::ACT_UNION, 10'd512, 10'd512);
		push_request(ufe_pkg::ACT_FIND, 10'd0, 10'd0);
		push_request(ufe_pkg::ACT_MAKE_SET, 10'd1023, 10'd0);
		push_request(ufe_pkg::ACT_FIND, 10'd0, 10'd0);
		for (int k = 0; k < 8; k++) begin
			push_request(ufe_pkg::ACT_UNION, ufe_pkg::node_t'(100 + k),
				ufe_pkg::node_t'(101 + k));
		end
		push_request(ufe_pkg::ACT_SAME, 10'd100, 10'd108);
		push_request(ufe_pkg::ACT_MAKE_SET, 10'd104, 10'd0);
		push_request(ufe_pkg::ACT_FIND, 10'd100, 10'd0);
		push_request(ufe_pkg::ACT_SAME, 10'd100, 10'd108);
		push_request(ufe_pkg::ACT_FIND, 10'd105, 10'd0);
		push_request(ufe_pkg::ACT_SAME, 10'h2AA, 10'h155);

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			@(negedge clk);
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 85;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 85;
				end
				default: begin
					send_idle_pct  = 34;
					recv_stall_pct = 34;
				end
			endcase
			added = 0;
			while (added < PHASE_ITEMS) begin
				mode = $urandom_range(99);
				base = ufe_pkg::node_t'($urandom_range(NODES - 1));
				if (mode < 12) begin
					// Build a parent chain, then search it from the far end
					len = ($urandom_range(99) < 5) ? $urandom_range(300, 150)
						: $urandom_range(40, 4);
					for (int k = 0; k < len; k++) begin
						push_request(ufe_pkg::ACT_UNION, base + ufe_pkg::node_t'(k),
							base + ufe_pkg::node_t'(k + 1));
					end
					push_request(ufe_pkg::ACT_SAME, base, base + ufe_pkg::node_t'(len));
					push_request(ufe_pkg::ACT_FIND, base, ufe_pkg::node_t'($urandom));
					added += len + 2;
				end else if (mode < 75) begin
					// Mixed actions inside a small node window
					span = $urandom_range(48, 8);
					len  = $urandom_range(30, 12);
					for (int k = 0; k < len; k++) begin
						mode = $urandom_range(99);
						push_request(mode < 40 ? ufe_pkg::ACT_UNION
							: mode < 65 ? ufe_pkg::ACT_FIND
							: mode < 90 ? ufe_pkg::ACT_SAME : ufe_pkg::ACT_MAKE_SET,
							base + ufe_pkg::node_t'($urandom_range(span - 1)),
							base + ufe_pkg::node_t'($urandom_range(span - 1)));
					end
					added += len;
				end else begin
					// Unrelated requests over the whole index range
					len = $urandom_range(5, 1);
					for (int k = 0; k < len; k++) begin
						push_request(ufe_pkg::action_t'($urandom),
							ufe_pkg::node_t'($urandom), ufe_pkg::node_t'($urandom));
					end
					added += len;
				end
			end
			while (backlog.size() != 0) @(negedge clk);
		end

		while (req_valid || answers_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
